/* hw/rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, codes and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int IN_DATA_BITS   = 136;
  localparam int OUT_DATA_BITS  = 72;

  localparam logic [2:0] OP_NORM  = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_CMP   = 3'd5;
  localparam logic [2:0] OP_TRUNC = 3'd6;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIVZ = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_FORM,
    ST_GCD,
    ST_GCDW,
    ST_DIVN,
    ST_DIVD,
    ST_TRUNC,
    ST_CHECK,
    ST_OUT
  } rau_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rau_div_stat_t;

endpackage

/* hw/rtl/rau_divider.sv */
// ----------------------------------------------------------------------------
// rau_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider #(
  parameter int MW = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [MW-1:0]          dividend,
  input  logic [MW-1:0]          divisor,
  output rau_pkg::rau_div_stat_t stat,
  output logic [MW-1:0]          quo,
  output logic [MW-1:0]          rem
);
  import rau_pkg::*;

  localparam int CW = $clog2(MW + 1);

  logic [MW:0]   rem_r, rem_nxt;
  logic [MW-1:0] quo_r, quo_nxt;
  logic [MW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [MW:0]   shifted, diff;

  always_comb begin
    shifted = {rem_r[MW-1:0], quo_r[MW-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (!diff[MW]) begin
      rem_nxt = diff;
      quo_nxt = {quo_r[MW-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_r[MW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
  assign rem       = rem_r[MW-1:0];

endmodule

/* hw/rtl/rau_mul.sv */
// ----------------------------------------------------------------------------
// rau_mul
// Signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rau_mul #(
  parameter int OW = 33
) (
  input  logic                 clk,
  input  logic signed [OW-1:0] op_a,
  input  logic signed [OW-1:0] op_b,
  output logic signed [2*OW-1:0] prod
);
  import rau_pkg::*;

  logic signed [2*OW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= (2*OW)'(op_a) * (2*OW)'(op_b);
  end

  assign prod = prod_r;

endmodule

/* hw/rtl/rational_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact rational arithmetic with GCD reduction under a small sequencer.
// ----------------------------------------------------------------------------
// Work per item: Euclid steps on the shared bit-serial divider, then one
// division each for numerator and denominator; truncate uses one division
// and compare none.
// One item at a time: in_tready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid.
module rational_arithmetic_unit_top #(
  parameter int WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // req_type[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
  input  logic [rau_pkg::IN_DATA_BITS-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // res_num[31:0], res_den[62:32], less_than[63], equal[64], status[66:65]
  output logic [rau_pkg::OUT_DATA_BITS-1:0]  out_tdata
);
  import rau_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int OW = W + 1;
  localparam int PW = 2 * OW;
  localparam int MW = 2 * W;
  localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);

  rau_state_t state_r, state_nxt;

  logic [2:0]          op_r;
  logic [31:0]         ra_num_r, ra_den_r, rb_num_r, rb_den_r;
  logic signed [OW-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [OW-1:0] an_v, ad_v, bn_v, bd_v;
  logic signed [PW-1:0] p_r [4];
  logic [2:0]          mcnt_r;
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] fn, fd, fn2, fd2;
  logic [MW-1:0]       mn_r, md_r, x_r, y_r, qn_r, qd_r;
  logic                neg_r, divz_r;
  logic [31:0]         res_num_r;
  logic [30:0]         res_den_r;
  logic                lt_r, eq_r;
  logic [1:0]          stat_r;
  logic                out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;

  logic                div_start;
  logic [MW-1:0]       div_dnd, div_dvs, div_quo, div_rem;
  rau_div_stat_t       div_stat;
  logic                in_fire, out_free;
  logic [MW-1:0]       an_abs, qn_sgn;
  logic                fit;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  rau_mul #(.OW(OW)) u_mul (
    .clk (clk),
    .op_a(mul_a),
    .op_b(mul_b),
    .prod(prod)
  );

  rau_divider #(.MW(MW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dnd),
    .divisor (div_dvs),
    .stat    (div_stat),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  // Operand normalisation: a zero denominator gives 0/1, a negative one
  // hands its sign to the numerator.
  always_comb begin
    an_v = OW'($signed(ra_num_r[W-1:0]));
    ad_v = OW'($signed(ra_den_r[W-1:0]));
    bn_v = OW'($signed(rb_num_r[W-1:0]));
    bd_v = OW'($signed(rb_den_r[W-1:0]));
    if (ad_v == '0) begin
      an_v = '0;
      ad_v = OW'(1);
    end else if (ad_v < 0) begin
      an_v = -an_v;
      ad_v = -ad_v;
    end
    if (bd_v == '0) begin
      bn_v = '0;
      bd_v = OW'(1);
    end else if (bd_v < 0) begin
      bn_v = -bn_v;
      bd_v = -bd_v;
    end
  end

  always_comb begin
    case (mcnt_r[1:0])
      2'd0:    begin mul_a = an_r; mul_b = bd_r; end
      2'd1:    begin mul_a = ad_r; mul_b = bn_r; end
      2'd2:    begin mul_a = an_r; mul_b = bn_r; end
      default: begin mul_a = ad_r; mul_b = bd_r; end
    endcase
  end

  assign an_abs = (an_r < 0) ? MW'(-PW'(an_r)) : MW'(PW'(an_r));

  // Unreduced result fraction; p_r holds an*bd, ad*bn, an*bn, ad*bd.
  always_comb begin
    fn = PW'(an_r);
    fd = PW'(ad_r);
    case (op_r)
      OP_ADD:  begin fn = p_r[0] + p_r[1]; fd = p_r[3]; end
      OP_SUB:  begin fn = p_r[0] - p_r[1]; fd = p_r[3]; end
      OP_MUL:  begin fn = p_r[2];          fd = p_r[3]; end
      OP_DIV: begin
        if (bn_r != '0) begin
          fn = p_r[0];
          fd = p_r[1];
        end
      end
      default: begin fn = PW'(an_r); fd = PW'(ad_r); end
    endcase
    if (fd < 0) begin
      fn2 = -fn;
      fd2 = -fd;
    end else begin
      fn2 = fn;
      fd2 = fd;
    end
  end

  always_comb begin
    qn_sgn = neg_r ? -qn_r : qn_r;
    fit    = (neg_r ? (qn_r <= LIM) : (qn_r < LIM)) && (qd_r < LIM);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL:   if (mcnt_r == 3'd4) state_nxt = ST_FORM;
      ST_FORM: begin
        case (op_r)
          OP_NORM, OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_nxt = ST_GCD;
          OP_TRUNC: state_nxt = ST_TRUNC;
          default:  state_nxt = ST_OUT;
        endcase
      end
      ST_GCD:   state_nxt = (y_r == '0) ? ST_DIVN : ST_GCDW;
      ST_GCDW:  if (div_stat.done) state_nxt = ST_GCD;
      ST_DIVN:  if (div_stat.done) state_nxt = ST_DIVD;
      ST_DIVD:  if (div_stat.done) state_nxt = ST_CHECK;
      ST_TRUNC: if (div_stat.done) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Divider control.
  always_comb begin
    div_start = 1'b0;
    div_dnd   = x_r;
    div_dvs   = y_r;
    case (state_r)
      ST_FORM: begin
        div_start = (op_r == OP_TRUNC);
        div_dnd   = an_abs;
        div_dvs   = MW'(PW'(ad_r));
      end
      ST_GCD: begin
        div_start = 1'b1;
        if (y_r == '0) begin
          div_dnd = mn_r;
          div_dvs = x_r;
        end
      end
      ST_DIVN: begin
        div_start = div_stat.done;
        div_dnd   = md_r;
        div_dvs   = x_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_r     <= in_tdata[2:0];
          ra_num_r <= in_tdata[34:3];
          ra_den_r <= in_tdata[66:35];
          rb_num_r <= in_tdata[98:67];
          rb_den_r <= in_tdata[130:99];
        end
      end
      ST_LOAD: begin
        an_r      <= an_v;
        ad_r      <= ad_v;
        bn_r      <= bn_v;
        bd_r      <= bd_v;
        mcnt_r    <= '0;
        res_num_r <= '0;
        res_den_r <= '0;
        lt_r      <= 1'b0;
        eq_r      <= 1'b0;
        stat_r    <= STAT_OK;
      end
      ST_MUL: begin
        mcnt_r <= mcnt_r + 1'b1;
        if (mcnt_r != '0) p_r[mcnt_r[1:0] - 2'd1] <= prod;
      end
      ST_FORM: begin
        divz_r <= (op_r == OP_DIV) && (bn_r == '0);
        neg_r  <= (op_r == OP_TRUNC) ? (an_r < 0) : (fn2 < 0);
        mn_r   <= (fn2 < 0) ? MW'(-fn2) : MW'(fn2);
        md_r   <= MW'(fd2);
        x_r    <= (fn2 < 0) ? MW'(-fn2) : MW'(fn2);
        y_r    <= MW'(fd2);
        if (op_r == OP_CMP) begin
          lt_r <= p_r[0] < p_r[1];
          eq_r <= p_r[0] == p_r[1];
        end
      end
      ST_GCDW: begin
        if (div_stat.done) begin
          x_r <= y_r;
          y_r <= div_rem;
        end
      end
      ST_DIVN:  if (div_stat.done) qn_r <= div_quo;
      ST_DIVD:  if (div_stat.done) qd_r <= div_quo;
      ST_TRUNC: begin
        if (div_stat.done) begin
          qn_r <= div_quo;
          qd_r <= MW'(1);
        end
      end
      ST_CHECK: begin
        if (divz_r) begin
          stat_r    <= STAT_DIVZ;
          res_num_r <= 32'($signed(qn_sgn[W-1:0]));
          res_den_r <= '0;
        end else if (!fit) begin
          stat_r <= STAT_OVF;
        end else begin
          res_num_r <= 32'($signed(qn_sgn[W-1:0]));
          res_den_r <= 31'(qd_r[W-2:0]);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_r <= {5'd0, stat_r, eq_r, lt_r, res_den_r, res_num_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_LOAD)
    else $error("accepted item did not start the sequence");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_divz_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66:65] == STAT_DIVZ |-> out_tdata[62:32] == '0)
    else $error("divide-by-zero result with non-zero denominator");

endmodule

/* tb/rational_arithmetic_unit_top_tb.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top_tb
// Streams operand pairs into the rational unit and checks every result
// against an exact wide-integer prediction, under random handshake gaps.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int N_RANDOM = 800;
  localparam longint CYCLE_LIMIT = 40000000;

  typedef logic signed [69:0] wide_t;
  localparam wide_t LIM = 70'sd2147483648;

  typedef struct {
    logic [IN_DATA_BITS-1:0] data;
    bit wait_drain;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_BITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;

  pending_t pending_q[$];
  logic [OUT_DATA_BITS-1:0] expected_q[$];
  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int n_results = 0;
  bit long_hold_done = 0;
  longint cycles = 0;

  rational_arithmetic_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Sign to the numerator, then divide both parts by their GCD; 0 den -> 0/1.
  function automatic void reduce_frac(input wide_t n, input wide_t d,
                                      output wide_t rn, output wide_t rd);
    wide_t x, y, t;
    if (d == 0) begin
      rn = 0;
      rd = 1;
    end else begin
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      x = (n < 0) ? -n : n;
      y = d;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      rn = n / x;
      rd = d / x;
    end
  endfunction

  function automatic logic [OUT_DATA_BITS-1:0] rational_result(
      input logic [IN_DATA_BITS-1:0] d);
    logic [2:0] op;
    wide_t an, ad, bn, bd, rn, rd;
    logic [31:0] num;
    logic [30:0] den;
    logic lt, eq;
    logic [1:0] st;
    op = d[2:0];
    reduce_frac(wide_t'($signed(d[34:3])), wide_t'($signed(d[66:35])), an, ad);
    reduce_frac(wide_t'($signed(d[98:67])), wide_t'($signed(d[130:99])), bn, bd);
    num = '0; den = '0; lt = 0; eq = 0; st = STAT_OK;
    rn = 0; rd = 1;
    case (op)
      OP_NORM: begin rn = an; rd = ad; end
      OP_ADD: reduce_frac(an * bd + ad * bn, ad * bd, rn, rd);
      OP_SUB: reduce_frac(an * bd - ad * bn, ad * bd, rn, rd);
      OP_MUL: reduce_frac(an * bn, ad * bd, rn, rd);
      OP_DIV: if (bn != 0) reduce_frac(an * bd, ad * bn, rn, rd);
      OP_TRUNC: begin rn = an / ad; rd = 1; end
      default: ;
    endcase
    if (op == OP_DIV && bn == 0) begin
      num = an[31:0];
      st = STAT_DIVZ;
    end else if (op == OP_CMP) begin
      lt = (an * bd < bn * ad);
      eq = (an == bn) && (ad == bd);
    end else if (op != OP_UNUSED) begin
      if (rn >= -LIM && rn <= LIM - 1 && rd <= LIM - 1) begin
        num = rn[31:0];
        den = rd[30:0];
      end else begin
        st = STAT_OVF;
      end
    end
    return {5'd0, st, eq, lt, den, num};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'($signed($urandom_range(0, 40)) - 20);
      5: return $urandom();
      6: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'd1;
          default: return 32'd0;
        endcase
      end
      7: return 32'd1 << $urandom_range(0, 31);
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic add_item(input logic [2:0] op, input logic [31:0] an,
                          input logic [31:0] ad, input logic [31:0] bn,
                          input logic [31:0] bd, input bit drain);
    pending_t p;
    p.data = {5'd0, bd, bn, ad, an, op};
    p.wait_drain = drain;
    pending_q.push_back(p);
  endtask

  // Driver: one item in flight on the input side, random gap before each.
  always @(posedge clk) begin
    bit nv;
    logic [IN_DATA_BITS-1:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(rational_result(in_tdata));
        nv = 0;
        send_gap = $urandom_range(0, 11);
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].wait_drain && expected_q.size() > 0)) begin
          nd = pending_q[0].data;
          pending_q.pop_front();
          nv = 1;
        end
      end
    end
    in_tvalid <= nv;
    in_tdata <= nd;
  end

  // Monitor: random stalls, plus one long hold-off after the hundredth result.
  always @(posedge clk) begin
    bit nr;
    nr = out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_tdata);
          errors++;
        end else begin
          if (out_tdata[31:0] !== expected_q[0][31:0])
            $display("%0t: res_num expected %h actual %h", $realtime,
                     expected_q[0][31:0], out_tdata[31:0]);
          if (out_tdata[62:32] !== expected_q[0][62:32])
            $display("%0t: res_den expected %h actual %h", $realtime,
                     expected_q[0][62:32], out_tdata[62:32]);
          if (out_tdata[63] !== expected_q[0][63])
            $display("%0t: less_than expected %b actual %b", $realtime,
                     expected_q[0][63], out_tdata[63]);
          if (out_tdata[64] !== expected_q[0][64])
            $display("%0t: equal expected %b actual %b", $realtime,
                     expected_q[0][64], out_tdata[64]);
          if (out_tdata[66:65] !== expected_q[0][66:65])
            $display("%0t: status expected %0d actual %0d", $realtime,
                     expected_q[0][66:65], out_tdata[66:65]);
          if (out_tdata !== expected_q[0]) errors++;
          expected_q.pop_front();
        end
        n_results++;
        nr = 0;
        if (n_results == 100 && !long_hold_done) begin
          recv_gap = 3000;
          long_hold_done = 1;
        end else begin
          recv_gap = (n_results % 5 < 2) ? 0 : $urandom_range(0, 11);
        end
      end
      if (!nr) begin
        if (recv_gap > 0) recv_gap--;
        else nr = 1;
      end
    end
    out_tready <= nr;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rational_arithmetic_unit_top test failed");
      $finish;
    end
  end

  initial begin
    logic [2:0] op;
    // Extremes, each operation, zero denominators, divide by zero,
    // overflow and the unused code.
    add_item(OP_NORM, 32'd6, 32'hffff_fffc, 32'd0, 32'd1, 0);
    add_item(OP_NORM, 32'd5, 32'd0, 32'd0, 32'd1, 0);
    add_item(OP_NORM, 32'd5, 32'h8000_0000, 32'd0, 32'd1, 0);
    add_item(OP_NORM, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd1, 0);
    add_item(OP_NORM, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 0);
    add_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 0);
    add_item(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1, 0);
    add_item(OP_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe, 0);
    add_item(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 0);
    add_item(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1, 0);
    add_item(OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1, 0);
    add_item(OP_MUL, 32'h8000_0000, 32'd3, 32'd3, 32'h8000_0000, 0);
    add_item(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd7, 0);
    add_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 32'd5, 32'd0, 0);
    add_item(OP_DIV, 32'd3, 32'd4, 32'hffff_fffe, 32'd5, 0);
    add_item(OP_CMP, 32'd1, 32'd2, 32'd2, 32'd4, 0);
    add_item(OP_CMP, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1, 0);
    add_item(OP_CMP, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe, 0);
    add_item(OP_TRUNC, 32'hffff_fff9, 32'd2, 32'd0, 32'd1, 0);
    add_item(OP_TRUNC, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd1, 0);
    add_item(OP_TRUNC, 32'd7, 32'd0, 32'd0, 32'd1, 0);
    add_item(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      op = 3'($urandom_range(0, 7));
      add_item(op, rand_word(), rand_word(), rand_word(), rand_word(),
               i == N_RANDOM / 2);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_q.size() > 0 || in_tvalid || expected_q.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("rational_arithmetic_unit_top test passed");
    end else begin
      $display("rational_arithmetic_unit_top test failed");
    end
    $finish;
  end
endmodule
